// ===== rtl/memory_read_byte_realigner_assert.svh =====
// Assertion macros for the memory read byte realigner checker.
// Expects clk and rst in the scope of each use.
`ifndef MEMORY_READ_BYTE_REALIGNER_ASSERT_SVH
`define MEMORY_READ_BYTE_REALIGNER_ASSERT_SVH

// same-cycle implication, off during reset
`define MRBR_ASSERT_NOW(label, cond, impl, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (impl)) \
    else $error(msg);

// next-cycle implication, off during reset
`define MRBR_ASSERT_NEXT(label, cond, impl, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (impl)) \
    else $error(msg);

// state seen in the cycle after reset
`define MRBR_ASSERT_RESET(label, impl, msg) \
  label: assert property (@(posedge clk) rst |=> (impl)) \
    else $error(msg);

`endif

// ===== rtl/mrbr_pkg.sv =====
// Shared constants and types for the memory read byte realigner.
// No dependencies; imported by every module of the block.
package mrbr_pkg;

  localparam int LANE_BYTES  = 8;
  localparam int WORD_BYTES  = 64;
  localparam int LANE_W      = 8 * LANE_BYTES;
  localparam int STRB_W      = LANE_BYTES;
  localparam int SHIFT_W     = $clog2(LANE_BYTES);
  localparam int WORD_OFF_W  = $clog2(WORD_BYTES);
  localparam int CFG_W       = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int POS_W       = CFG_W + 2;
  localparam int LANE_CNT_W  = POS_W - SHIFT_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;
  localparam int OUT_DEPTH   = 2;
  localparam int OCNT_W      = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_OFFSET = 1'b0,
    REG_BYTE_COUNT   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              a_valid;
    logic [LANE_W-1:0] a_data;
    logic [STRB_W-1:0] a_strobe;
    logic [LANE_W-1:0] b_data;
    logic [STRB_W-1:0] b_strobe;
    logic              last;
  } op_t;

  typedef struct packed {
    logic [LANE_W-1:0] data;
    logic [STRB_W-1:0] strobe;
    logic              last;
  } res_t;

endpackage

// ===== rtl/mrbr_queue.sv =====
// Two-entry register queue of classified lanes between front and back.
// Depends on mrbr_pkg.
module mrbr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mrbr_pkg::op_t in_op,
  output logic          out_valid,
  input  logic          out_ready,
  output mrbr_pkg::op_t out_op
);
  import mrbr_pkg::*;

  op_t               entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready  = count != QCNT_W'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_op    = entry[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_op;
    end
  end

endmodule

// ===== rtl/mrbr_front.sv =====
// Front end: configuration registers, byte strobe generation, lane shift and carry.
// Depends on mrbr_pkg; feeds classified lanes to mrbr_queue.
module mrbr_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mrbr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mrbr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           lane_valid,
  output logic                           lane_ready,
  input  logic [mrbr_pkg::LANE_W-1:0]    lane_data,
  input  logic                           lane_last,
  output logic                           op_valid,
  input  logic                           op_ready,
  output mrbr_pkg::op_t                  op
);
  import mrbr_pkg::*;

  logic [CFG_W-1:0]      start_offset;
  logic [CFG_W-1:0]      byte_count;
  logic [LANE_CNT_W-1:0] lane_cnt;
  logic [LANE_CNT_W-1:0] lane_cnt_next;
  logic [LANE_W-1:0]     carry_data;
  logic [STRB_W-1:0]     carry_strobe;
  logic                  carry_valid;

  logic [SHIFT_W-1:0]    shift;
  logic [SHIFT_W:0]      inv_shift;
  logic [POS_W-1:0]      range_lo;
  logic [POS_W-1:0]      range_hi;
  logic [POS_W-1:0]      base_pos;
  logic [POS_W-1:0]      byte_pos [LANE_BYTES];
  logic [STRB_W-1:0]     lane_strobe;
  logic                  accept;

  assign shift     = start_offset[SHIFT_W-1:0];
  assign inv_shift = (SHIFT_W + 1)'(LANE_BYTES) - {1'b0, shift};
  assign range_lo  = POS_W'(start_offset[WORD_OFF_W-1:0]);
  assign range_hi  = POS_W'(start_offset[WORD_OFF_W-1:0]) + POS_W'(byte_count);
  assign base_pos  = {lane_cnt, SHIFT_W'(0)};

  always_comb begin
    for (int b = 0; b < LANE_BYTES; b++) begin
      byte_pos[b]    = base_pos + POS_W'(b);
      lane_strobe[b] = (byte_pos[b] >= range_lo) && (byte_pos[b] < range_hi);
    end
  end

  always_comb begin
    op.a_valid  = carry_valid;
    op.a_data   = carry_data | (lane_data << {inv_shift, 3'b000});
    op.a_strobe = carry_strobe | (lane_strobe << inv_shift);
    op.b_data   = lane_data >> {shift, 3'b000};
    op.b_strobe = lane_strobe >> shift;
    op.last     = lane_last;
  end

  assign op_valid      = lane_valid;
  assign lane_ready    = op_ready;
  assign accept        = lane_valid && op_ready;
  assign lane_cnt_next = lane_cnt[LANE_CNT_W-1] ? lane_cnt : lane_cnt + LANE_CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset <= '0;
      byte_count   <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_OFFSET: start_offset <= cfg_wdata;
        REG_BYTE_COUNT:   byte_count   <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_valid  <= 1'b0;
      carry_strobe <= '0;
      lane_cnt     <= '0;
    end else if (accept) begin
      if (lane_last) begin
        carry_valid  <= 1'b0;
        carry_strobe <= '0;
        lane_cnt     <= '0;
      end else begin
        carry_valid  <= 1'b1;
        carry_strobe <= op.b_strobe;
        lane_cnt     <= lane_cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      carry_data <= op.b_data;
    end
  end

endmodule

// ===== rtl/mrbr_back.sv =====
// Back end: held element, empty-element drop, last marking and output buffer.
// Depends on mrbr_pkg; drains mrbr_queue.
module mrbr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        op_valid,
  output logic                        op_ready,
  input  mrbr_pkg::op_t               op,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [mrbr_pkg::LANE_W-1:0] m_tdata,
  output logic [mrbr_pkg::STRB_W-1:0] m_tuser,
  output logic                        m_tlast
);
  import mrbr_pkg::*;

  logic              held_valid;
  logic [LANE_W-1:0] held_data;
  logic [STRB_W-1:0] held_strobe;
  logic              held_valid_next;
  logic [LANE_W-1:0] held_data_next;
  logic [STRB_W-1:0] held_strobe_next;

  res_t              obuf [OUT_DEPTH];
  res_t              obuf_next [OUT_DEPTH];
  logic [OCNT_W-1:0] obuf_cnt;
  logic [OCNT_W-1:0] remain;
  logic [OCNT_W:0]   free_slots;
  logic              deq;

  res_t              res0;
  res_t              res1;
  logic [OCNT_W-1:0] n_res;

  always_comb begin
    n_res            = '0;
    res0             = '0;
    res1             = '0;
    held_valid_next  = held_valid;
    held_data_next   = held_data;
    held_strobe_next = held_strobe;
    if (op.a_valid) begin
      if (op.a_strobe != '0) begin
        if (held_valid_next) begin
          if (n_res == '0) res0 = '{held_data_next, held_strobe_next, 1'b0};
          else             res1 = '{held_data_next, held_strobe_next, 1'b0};
          n_res = n_res + OCNT_W'(1);
        end
        held_valid_next  = 1'b1;
        held_data_next   = op.a_data;
        held_strobe_next = op.a_strobe;
      end
      if (held_valid_next && op.b_strobe != '0) begin
        if (n_res == '0) res0 = '{held_data_next, held_strobe_next, 1'b0};
        else             res1 = '{held_data_next, held_strobe_next, 1'b0};
        n_res           = n_res + OCNT_W'(1);
        held_valid_next = 1'b0;
      end
    end
    if (op.last) begin
      if (op.b_strobe != '0) begin
        if (held_valid_next) begin
          if (n_res == '0) res0 = '{held_data_next, held_strobe_next, 1'b0};
          else             res1 = '{held_data_next, held_strobe_next, 1'b0};
          n_res = n_res + OCNT_W'(1);
        end
        held_valid_next  = 1'b1;
        held_data_next   = op.b_data;
        held_strobe_next = op.b_strobe;
      end
      if (held_valid_next) begin
        if (n_res == '0) res0 = '{held_data_next, held_strobe_next, 1'b1};
        else             res1 = '{held_data_next, held_strobe_next, 1'b1};
        n_res = n_res + OCNT_W'(1);
      end
      held_valid_next = 1'b0;
    end
  end

  assign deq        = m_tvalid && m_tready;
  assign remain     = obuf_cnt - OCNT_W'(deq);
  assign free_slots = (OCNT_W + 1)'(OUT_DEPTH) - {1'b0, remain};
  assign op_ready   = {1'b0, n_res} <= free_slots;

  always_comb begin
    obuf_next = obuf;
    if (deq) begin
      obuf_next[0] = obuf[1];
    end
    if (op_valid && op_ready) begin
      if (n_res == OCNT_W'(2)) begin
        obuf_next[0] = res0;
        obuf_next[1] = res1;
      end else if (n_res == OCNT_W'(1)) begin
        obuf_next[remain[0]] = res0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      obuf_cnt   <= '0;
    end else begin
      obuf_cnt <= remain + ((op_valid && op_ready) ? n_res : OCNT_W'(0));
      if (op_valid && op_ready) begin
        held_valid <= held_valid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    obuf <= obuf_next;
    if (op_valid && op_ready) begin
      held_data   <= held_data_next;
      held_strobe <= held_strobe_next;
    end
  end

  assign m_tvalid = obuf_cnt != '0;
  assign m_tdata  = obuf[0].data;
  assign m_tuser  = obuf[0].strobe;
  assign m_tlast  = obuf[0].last;

endmodule

// ===== rtl/memory_read_byte_realigner.sv =====
// Top level of the memory read byte realigner.
// Depends on mrbr_pkg, mrbr_front, mrbr_queue and mrbr_back.
//
// Usage:
//   Write start_offset (index 0) and byte_count (index 1) through cfg_we,
//   cfg_index and cfg_wdata while no transfer is in flight. Then send the
//   8-byte lanes of the memory words that cover the range on the s_ stream,
//   lowest address first, with s_tlast on the final lane. The m_ stream
//   returns packed 8-byte elements, first byte in bits 7:0, with a byte
//   strobe on m_tuser and m_tlast on the final element. Empty elements are
//   dropped; a transfer with no valid byte returns nothing.
//   Rate: one lane per cycle while s_tready is high. An element passes
//   the lane queue and output buffer registers after the lane that
//   completes it, or after the next lane that shows it is not the last.
//   A lane that completes two elements needs two output transfers,
//   absorbed by the two-entry lane queue and the two-entry output buffer.
//   The carry and lane count (front) and held element (back) pass state across lanes.
//   Reset clears the carry, held element, queue and output buffer and sets
//   start_offset 0 and byte_count 1. When m_tready stays low the output
//   buffer fills, then the queue, then s_tready drops; nothing is lost.
module memory_read_byte_realigner (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mrbr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mrbr_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [mrbr_pkg::LANE_W-1:0]      s_tdata,   // lane_data[63:0]
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [mrbr_pkg::LANE_W-1:0]      m_tdata,   // out_data[63:0]
  output logic [mrbr_pkg::STRB_W-1:0]      m_tuser,   // out_strobe[7:0]
  output logic                             m_tlast
);
  import mrbr_pkg::*;

  logic front_valid;
  logic front_ready;
  op_t  front_op;
  logic back_valid;
  logic back_ready;
  op_t  back_op;

  mrbr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .lane_valid (s_tvalid),
    .lane_ready (s_tready),
    .lane_data  (s_tdata),
    .lane_last  (s_tlast),
    .op_valid   (front_valid),
    .op_ready   (front_ready),
    .op         (front_op)
  );

  mrbr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_op     (front_op),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_op    (back_op)
  );

  mrbr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (back_valid),
    .op_ready (back_ready),
    .op       (back_op),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== rtl/mrbr_checker.sv =====
// Port-level checker for the memory read byte realigner, bound to the top level.
// Depends on mrbr_pkg and memory_read_byte_realigner_assert.svh.
`include "memory_read_byte_realigner_assert.svh"

module mrbr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [mrbr_pkg::LANE_W-1:0] m_tdata,
  input logic [mrbr_pkg::STRB_W-1:0] m_tuser,
  input logic                        m_tlast
);
  import mrbr_pkg::*;

  `MRBR_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output changed while stalled")
  `MRBR_ASSERT_NOW(a_no_empty_element, m_tvalid, m_tuser != '0, "element with empty strobe sent")
  `MRBR_ASSERT_RESET(a_reset_quiet, !m_tvalid, "output valid right after reset")
  `MRBR_ASSERT_RESET(a_reset_ready, s_tready, "input not ready right after reset")

endmodule

bind memory_read_byte_realigner mrbr_checker u_checker (.*);
